// ===== src/cnms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cnms_pkg;

    localparam int CFG_ADDR_BITS = 5;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_L2_MODE      = 3'd2;
    localparam logic [2:0] REG_LOW_THRESH   = 3'd3;
    localparam logic [2:0] REG_HIGH_THRESH  = 3'd4;

    localparam logic [14:0] T22_Q16 = 15'd27146;
    localparam logic [17:0] T67_Q16 = 18'd158218;

    localparam int MAX_HEIGHT = 4096;

    localparam logic [1:0] CLASS_NONE   = 2'd0;
    localparam logic [1:0] CLASS_WEAK   = 2'd1;
    localparam logic [1:0] CLASS_STRONG = 2'd2;

    typedef enum logic [1:0] {
        DIR_HORZ = 2'd0,
        DIR_DIAG = 2'd1,
        DIR_VERT = 2'd2,
        DIR_ANTI = 2'd3
    } dir_t;

    typedef struct packed {
        logic [10:0] image_width;
        logic [12:0] image_height;
        logic        l2_mode;
        logic [7:0]  low_threshold;
        logic [7:0]  high_threshold;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } tag_t;

endpackage
`default_nettype wire

// ===== src/cnms_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cnms_regs
    import cnms_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width    <= 11'd640;
            cfg_reg.image_height   <= 13'd480;
            cfg_reg.l2_mode        <= 1'b0;
            cfg_reg.low_threshold  <= 8'd50;
            cfg_reg.high_threshold <= 8'd150;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_IMAGE_WIDTH:  cfg_reg.image_width    <= pwdata[10:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height   <= pwdata[12:0];
                REG_L2_MODE:      cfg_reg.l2_mode        <= pwdata[0];
                REG_LOW_THRESH:   cfg_reg.low_threshold  <= pwdata[7:0];
                REG_HIGH_THRESH:  cfg_reg.high_threshold <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_IMAGE_WIDTH:  prdata = {21'd0, cfg_reg.image_width};
            REG_IMAGE_HEIGHT: prdata = {19'd0, cfg_reg.image_height};
            REG_L2_MODE:      prdata = {31'd0, cfg_reg.l2_mode};
            REG_LOW_THRESH:   prdata = {24'd0, cfg_reg.low_threshold};
            REG_HIGH_THRESH:  prdata = {24'd0, cfg_reg.high_threshold};
            default:          prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/cnms_mag.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cnms_mag
    import cnms_pkg::*;
#(
    parameter int GRAD_BITS = 16,
    parameter int CW        = 10
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 l2_mode,
    input  wire tag_t                 in_tag,
    input  wire logic [CW-1:0]        in_col,
    input  wire logic [GRAD_BITS-1:0] grad_x,
    input  wire logic [GRAD_BITS-1:0] grad_y,
    output tag_t                      out_tag,
    output logic      [CW-1:0]        out_col,
    output logic      [GRAD_BITS:0]   out_mag,
    output dir_t                      out_dir
);

    localparam int G  = GRAD_BITS;
    localparam int SW = 2 * G;
    localparam int PW = G + 18;

    tag_t            s1_tag_reg, s2_tag_reg;
    logic [CW-1:0]   s1_col_reg, s2_col_reg;
    logic [G-1:0]    ax1_reg, ay1_reg, ay2_reg;
    logic            same1_reg, same2_reg, zero2_reg;
    logic [SW-1:0]   sqx2_reg, sqy2_reg;
    logic [G+14:0]   p22_reg;
    logic [G+17:0]   p67_reg;
    logic [G:0]      l1_2_reg;

    tag_t            tag_q   [0:G];
    logic [CW-1:0]   col_q   [0:G];
    dir_t            dir_q   [0:G];
    logic [G:0]      l1_q    [0:G];
    logic [SW-1:0]   rem_q   [0:G];
    logic [G-1:0]    root_q  [0:G];
    logic [SW-1:0]   trial   [0:G-1];

    logic [G-1:0]    ax, ay;
    logic [PW-1:0]   ay_sh, p22_ext, p67_ext;
    dir_t            dir_next;
    logic [G:0]      root_ext;

    tag_t            out_tag_reg;
    logic [CW-1:0]   out_col_reg;
    logic [G:0]      out_mag_reg;
    dir_t            out_dir_reg;

    assign ax = grad_x[G-1] ? (~grad_x + 1'b1) : grad_x;
    assign ay = grad_y[G-1] ? (~grad_y + 1'b1) : grad_y;

    assign ay_sh   = {2'b00, ay2_reg, 16'd0};
    assign p22_ext = {3'b000, p22_reg};
    assign p67_ext = p67_reg;

    always_comb
    begin
        if (zero2_reg || ay_sh < p22_ext)
            dir_next = DIR_HORZ;
        else if (ay_sh >= p67_ext)
            dir_next = DIR_VERT;
        else if (same2_reg)
            dir_next = DIR_DIAG;
        else
            dir_next = DIR_ANTI;
    end

    always_comb
    begin
        for (int j = 0; j < G; j++)
        begin
            trial[j] = (SW'(root_q[j]) << (G - j)) + (SW'(1) << (2 * (G - 1 - j)));
        end
    end

    assign root_ext = {1'b0, root_q[G]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg  <= '0;
            s2_tag_reg  <= '0;
            out_tag_reg <= '0;
            for (int j = 0; j <= G; j++)
            begin
                tag_q[j] <= '0;
            end
        end
        else if (en)
        begin
            s1_tag_reg  <= in_tag;
            s2_tag_reg  <= s1_tag_reg;
            tag_q[0]    <= s2_tag_reg;
            for (int j = 0; j < G; j++)
            begin
                tag_q[j+1] <= tag_q[j];
            end
            out_tag_reg <= tag_q[G];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_col_reg <= in_col;
            ax1_reg    <= ax;
            ay1_reg    <= ay;
            same1_reg  <= (grad_x[G-1] == grad_y[G-1]);

            s2_col_reg <= s1_col_reg;
            sqx2_reg   <= SW'(ax1_reg * ax1_reg);
            sqy2_reg   <= SW'(ay1_reg * ay1_reg);
            p22_reg    <= T22_Q16 * ax1_reg;
            p67_reg    <= T67_Q16 * ax1_reg;
            ay2_reg    <= ay1_reg;
            l1_2_reg   <= {1'b0, ax1_reg} + {1'b0, ay1_reg};
            zero2_reg  <= (ax1_reg == '0) && (ay1_reg == '0);
            same2_reg  <= same1_reg;

            col_q[0]  <= s2_col_reg;
            dir_q[0]  <= dir_next;
            l1_q[0]   <= l1_2_reg;
            rem_q[0]  <= sqx2_reg + sqy2_reg;
            root_q[0] <= '0;

            for (int j = 0; j < G; j++)
            begin
                col_q[j+1] <= col_q[j];
                dir_q[j+1] <= dir_q[j];
                l1_q[j+1]  <= l1_q[j];
                if (rem_q[j] >= trial[j])
                begin
                    rem_q[j+1]  <= rem_q[j] - trial[j];
                    root_q[j+1] <= root_q[j] | (G'(1) << (G - 1 - j));
                end
                else
                begin
                    rem_q[j+1]  <= rem_q[j];
                    root_q[j+1] <= root_q[j];
                end
            end

            out_col_reg <= col_q[G];
            out_dir_reg <= dir_q[G];
            if (!l2_mode)
                out_mag_reg <= l1_q[G];
            else if (rem_q[G] > SW'(root_q[G]))
                out_mag_reg <= root_ext + 1'b1;
            else
                out_mag_reg <= root_ext;
        end
    end

    assign out_tag = out_tag_reg;
    assign out_col = out_col_reg;
    assign out_mag = out_mag_reg;
    assign out_dir = out_dir_reg;

endmodule
`default_nettype wire

// ===== src/cnms_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cnms_window
    import cnms_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10,
    parameter int MW        = 17
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire tag_t          in_tag,
    input  wire logic [CW-1:0] in_col,
    input  wire logic [MW-1:0] in_mag,
    input  wire dir_t          in_dir,
    output logic               en,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic      [7:0]    out_magnitude,
    output logic      [1:0]    out_class,
    output logic               out_last
);

    logic [MW-1:0] line0_mem [MAX_WIDTH];
    logic [MW-1:0] line1_mem [MAX_WIDTH];
    dir_t          dir_mem   [MAX_WIDTH];

    tag_t          a_tag_reg, b_tag_reg;
    logic [CW-1:0] a_col_reg;
    logic [MW-1:0] a_mag_reg, rd0_reg, rd1_reg;
    dir_t          a_dir_reg, rdd_reg;

    logic [MW-1:0] win_reg [3][3];
    dir_t          wd1_reg, wd2_reg;

    logic          out_valid_reg, out_last_reg;
    logic [7:0]    out_mag_reg;
    logic [1:0]    out_class_reg;

    logic [MW-1:0] centre, up, down, kept;
    logic [7:0]    sat;
    logic [1:0]    cls;

    assign en = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_col_reg <= in_col;
            a_mag_reg <= in_mag;
            a_dir_reg <= in_dir;
            rd0_reg   <= line0_mem[in_col];
            rd1_reg   <= line1_mem[in_col];
            rdd_reg   <= dir_mem[in_col];
            if (a_tag_reg.valid)
            begin
                line0_mem[a_col_reg] <= rd1_reg;
                line1_mem[a_col_reg] <= a_mag_reg;
                dir_mem[a_col_reg]   <= a_dir_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tag_reg     <= '0;
            b_tag_reg     <= '0;
            wd1_reg       <= DIR_HORZ;
            wd2_reg       <= DIR_HORZ;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[i][k] <= '0;
                end
            end
        end
        else if (en)
        begin
            a_tag_reg     <= in_tag;
            b_tag_reg     <= a_tag_reg;
            out_valid_reg <= b_tag_reg.valid && b_tag_reg.emit;
            if (a_tag_reg.valid)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= rd0_reg;
                win_reg[1][2] <= rd1_reg;
                win_reg[2][2] <= a_mag_reg;
                wd1_reg       <= wd2_reg;
                wd2_reg       <= rdd_reg;
            end
        end
    end

    assign centre = win_reg[1][1];

    always_comb
    begin
        case (wd1_reg)
            DIR_HORZ:
            begin
                up   = win_reg[1][0];
                down = win_reg[1][2];
            end
            DIR_DIAG:
            begin
                up   = win_reg[0][0];
                down = win_reg[2][2];
            end
            DIR_VERT:
            begin
                up   = win_reg[0][1];
                down = win_reg[2][1];
            end
            default:
            begin
                up   = win_reg[0][2];
                down = win_reg[2][0];
            end
        endcase
        kept = (centre >= up && centre >= down) ? centre : '0;
        sat  = (kept > MW'(255)) ? 8'd255 : kept[7:0];
        if (sat >= cfg.high_threshold)
            cls = CLASS_STRONG;
        else if (sat < cfg.low_threshold)
            cls = CLASS_NONE;
        else
            cls = CLASS_WEAK;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_mag_reg   <= sat;
            out_class_reg <= cls;
            out_last_reg  <= b_tag_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_magnitude = out_mag_reg;
    assign out_class     = out_class_reg;
    assign out_last      = out_last_reg;

endmodule
`default_nettype wire

// ===== src/canny_non_max_suppression.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Canny non-maximum suppression over a raster stream of (grad_x, grad_y) pixels.
// One pixel is accepted per clock while the output is not stalled; each result
// passes the magnitude pipeline, whose square root resolves one bit per stage,
// and then the window. The whole pipeline holds while the output item waits.
// Results exist only for interior pixels, so border pixels produce no item.
// Line buffers are MAX_WIDTH deep; configure only while the block is idle.
module canny_non_max_suppression
    import cnms_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int GRAD_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [((2*GRAD_BITS+7)/8)*8-1:0] s_tdata,   // grad_x, grad_y
    input  wire logic                     s_tuser,   // start_of_frame
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic      [15:0]              m_tdata,   // nms_magnitude, edge_class
    output logic                          m_tlast,   // last_of_frame
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready
);

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int RW       = 12;

    cfg_t           cfg;
    logic           en, accept;
    logic [CW-1:0]  col_reg, col_next, wm1, c0, c;
    logic [RW-1:0]  row_reg, row_next, hm1, r0, r;
    tag_t           pix_tag, mag_tag;
    logic [CW-1:0]  mag_col;
    logic [GRAD_BITS:0] mag;
    dir_t           mag_dir;
    logic [7:0]     out_mag;
    logic [1:0]     out_cls;

    cnms_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready = en;
    assign accept   = s_tvalid && en;

    always_comb
    begin
        if (cfg.image_width < 11'd3)
            wm1 = CW'(2);
        else if (32'(cfg.image_width) > MAX_WIDTH)
            wm1 = CW'(MAX_WIDTH - 1);
        else
            wm1 = CW'(32'(cfg.image_width) - 1);
        if (cfg.image_height < 13'd3)
            hm1 = RW'(2);
        else if (32'(cfg.image_height) > MAX_HEIGHT)
            hm1 = RW'(MAX_HEIGHT - 1);
        else
            hm1 = RW'(32'(cfg.image_height) - 1);

        c0 = s_tuser ? '0 : col_reg;
        r0 = s_tuser ? '0 : row_reg;
        c  = (c0 > wm1) ? wm1 : c0;
        r  = (r0 > hm1) ? hm1 : r0;

        if (c >= wm1)
        begin
            col_next = '0;
            row_next = (r >= hm1) ? '0 : r + 1'b1;
        end
        else
        begin
            col_next = c + 1'b1;
            row_next = r;
        end

        pix_tag.valid = accept;
        pix_tag.emit  = (r >= RW'(2)) && (c >= CW'(2));
        pix_tag.last  = (r == hm1) && (c == wm1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    cnms_mag #(
        .GRAD_BITS (GRAD_BITS),
        .CW        (CW)
    ) u_mag (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .l2_mode (cfg.l2_mode),
        .in_tag  (pix_tag),
        .in_col  (c),
        .grad_x  (s_tdata[GRAD_BITS-1:0]),
        .grad_y  (s_tdata[2*GRAD_BITS-1:GRAD_BITS]),
        .out_tag (mag_tag),
        .out_col (mag_col),
        .out_mag (mag),
        .out_dir (mag_dir)
    );

    cnms_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW),
        .MW        (GRAD_BITS + 1)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_tag        (mag_tag),
        .in_col        (mag_col),
        .in_mag        (mag),
        .in_dir        (mag_dir),
        .en            (en),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_magnitude (out_mag),
        .out_class     (out_cls),
        .out_last      (m_tlast)
    );

    assign m_tdata = {6'd0, out_cls, out_mag};

endmodule
`default_nettype wire

// ===== verif/cnms_checker.sv =====
`timescale 1ns / 1ps
module cnms_checker
    import cnms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          pending
);

    localparam int MAXW = 1024;

    typedef struct {
        logic [7:0] mag;
        logic [1:0] cls;
        logic       last;
    } nms_result_t;

    nms_result_t expected_pixels[$];

    cfg_t        cfg;
    logic [16:0] mag_line[2][MAXW];
    dir_t        dir_line[MAXW];
    logic [16:0] win[3][3];
    dir_t        win_dir[3];
    int unsigned col;
    int unsigned row;

    function automatic logic [16:0] abs_grad(logic [15:0] raw);
        if (raw[15])
            return 17'h10000 - {1'b0, raw};
        return {1'b0, raw};
    endfunction

    function automatic logic [16:0] round_root(logic [63:0] s);
        logic [63:0] root;
        logic [63:0] cand;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (cand * cand <= s)
                root = cand;
        end
        if (s > root * root + root)
            root = root + 1;
        return root[16:0];
    endfunction

    function automatic dir_t sector(logic [15:0] gx, logic [15:0] gy,
                                    logic [16:0] ax, logic [16:0] ay);
        logic [63:0] lhs;
        lhs = {47'd0, ay} << 16;
        if (ax == 0 && ay == 0)
            return DIR_HORZ;
        if (lhs < 64'd27146 * ax)
            return DIR_HORZ;
        if (lhs >= 64'd158218 * ax)
            return DIR_VERT;
        return (gx[15] == gy[15]) ? DIR_DIAG : DIR_ANTI;
    endfunction

    task automatic predict_pixel(logic [15:0] gx, logic [15:0] gy, logic sof);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic [16:0] ax;
        logic [16:0] ay;
        logic [16:0] mag;
        logic [16:0] up;
        logic [16:0] down;
        logic [16:0] kept;
        dir_t        d;
        nms_result_t res;
        w = cfg.image_width < 3 ? 3 : (cfg.image_width > MAXW ? MAXW : cfg.image_width);
        h = cfg.image_height < 3 ? 3 :
            (cfg.image_height > MAX_HEIGHT ? MAX_HEIGHT : cfg.image_height);
        ax = abs_grad(gx);
        ay = abs_grad(gy);
        if (sof)
        begin
            col = 0;
            row = 0;
        end
        if (col > w - 1)
            col = w - 1;
        if (row > h - 1)
            row = h - 1;
        c = col;
        r = row;
        if (cfg.l2_mode)
            mag = round_root({47'd0, ax} * ax + {47'd0, ay} * ay);
        else
            mag = ax + ay;
        d = sector(gx, gy, ax, ay);
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = mag_line[0][c];
        win[1][2] = mag_line[1][c];
        win[2][2] = mag;
        win_dir[0] = win_dir[1];
        win_dir[1] = win_dir[2];
        win_dir[2] = dir_line[c];
        mag_line[0][c] = mag_line[1][c];
        mag_line[1][c] = mag;
        dir_line[c] = d;
        if (r >= 2 && c >= 2)
        begin
            case (win_dir[1])
                DIR_HORZ: begin up = win[1][0]; down = win[1][2]; end
                DIR_DIAG: begin up = win[0][0]; down = win[2][2]; end
                DIR_VERT: begin up = win[0][1]; down = win[2][1]; end
                default:  begin up = win[0][2]; down = win[2][0]; end
            endcase
            kept = (win[1][1] >= up && win[1][1] >= down) ? win[1][1] : 17'd0;
            res.mag = kept > 255 ? 8'd255 : kept[7:0];
            if (res.mag >= cfg.high_threshold)
                res.cls = CLASS_STRONG;
            else if (res.mag < cfg.low_threshold)
                res.cls = CLASS_NONE;
            else
                res.cls = CLASS_WEAK;
            res.last = (r == h - 1) && (c == w - 1);
            expected_pixels.push_back(res);
        end
        if (c >= w - 1)
        begin
            col = 0;
            row = (r >= h - 1) ? 0 : r + 1;
        end
        else
            col = c + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        nms_result_t want;
        if (!rst_n)
        begin
            cfg.image_width    = 11'd640;
            cfg.image_height   = 13'd480;
            cfg.l2_mode        = 1'b0;
            cfg.low_threshold  = 8'd50;
            cfg.high_threshold = 8'd150;
            for (int i = 0; i < MAXW; i++)
            begin
                mag_line[0][i] = 0;
                mag_line[1][i] = 0;
                dir_line[i] = DIR_HORZ;
            end
            for (int i = 0; i < 3; i++)
            begin
                win_dir[i] = DIR_HORZ;
                for (int j = 0; j < 3; j++)
                    win[i][j] = 0;
            end
            col = 0;
            row = 0;
            expected_pixels.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_BITS-1:2])
                    REG_IMAGE_WIDTH:  cfg.image_width    = pwdata[10:0];
                    REG_IMAGE_HEIGHT: cfg.image_height   = pwdata[12:0];
                    REG_L2_MODE:      cfg.l2_mode        = pwdata[0];
                    REG_LOW_THRESH:   cfg.low_threshold  = pwdata[7:0];
                    REG_HIGH_THRESH:  cfg.high_threshold = pwdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_pixel(s_tdata[15:0], s_tdata[31:16], s_tuser);
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected item mag=%0d class=%0d last=%0b",
                             $realtime, m_tdata[7:0], m_tdata[9:8], m_tlast);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_tdata[7:0] !== want.mag || m_tdata[9:8] !== want.cls
                        || m_tlast !== want.last)
                    begin
                        $display("%0t: mismatch expected mag=%0d class=%0d last=%0b, got mag=%0d class=%0d last=%0b",
                                 $realtime, want.mag, want.cls, want.last,
                                 m_tdata[7:0], m_tdata[9:8], m_tlast);
                        errors++;
                    end
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top
    import cnms_pkg::*;
();

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN = 60;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int sent;
    int burst_left;
    int frame_w;
    int frame_h;
    int idle_cycles;
    bit hold_done;

    canny_non_max_suppression dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cnms_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: stall pattern rotates through four modes, one long hold
    initial
    begin
        int cyc;
        cyc = 0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!hold_done && sent >= 600)
            begin
                hold_done = 1;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                case ((cyc / 300) % 4)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 4) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_frame(int w, int h);
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
        frame_w = w < 3 ? 3 : (w > 1024 ? 1024 : w);
        frame_h = h < 3 ? 3 : (h > MAX_HEIGHT ? MAX_HEIGHT : h);
    endtask

    task automatic send_pixel(logic [15:0] gx, logic [15:0] gy, logic sof);
        bit ok;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {gy, gx};
        s_tuser  <= sof;
        forever
        begin
            @(negedge clk);
            ok = s_tready;
            @(posedge clk);
            if (ok)
                break;
        end
        sent++;
    endtask

    function automatic logic [15:0] rand_grad();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom();
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'h8001;
                    default: v = 16'h0000;
                endcase
            end
            default:
            begin
                v = $urandom_range(0, 180);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // stop early after 'stop_at' pixels when nonnegative
    task automatic send_frame(bit sof, int stop_at);
        int n;
        n = 0;
        for (int r = 0; r < frame_h; r++)
            for (int c = 0; c < frame_w; c++)
            begin
                if (stop_at >= 0 && n >= stop_at)
                    return;
                send_pixel(rand_grad(), rand_grad(), sof && r == 0 && c == 0);
                n++;
            end
    endtask

    initial
    begin
        logic [15:0] dir_x[20];
        logic [15:0] dir_y[20];
        sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        frame_w = 640;
        frame_h = 480;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_x = '{16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF,
                  16'd5, -16'sd5, 16'd10, 16'd3, 16'd100, 16'h8001, 16'd0, 16'd60,
                  -16'sd60, 16'd200, 16'd1, 16'hFFFF, 16'd40};
        dir_y = '{16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 16'h8000, 16'h8001,
                  16'd5, 16'd5, 16'd3, 16'd10, 16'd41, 16'h7FFF, 16'd1, -16'sd60,
                  -16'sd25, 16'd242, 16'd0, 16'hFFFF, 16'd97};
        set_frame(5, 4);
        for (int i = 0; i < 20; i++)
            send_pixel(dir_x[i], dir_y[i], i == 0);
        wait_idle();
        cfg_write(REG_L2_MODE, 1);
        cfg_write(REG_LOW_THRESH, 0);
        cfg_write(REG_HIGH_THRESH, 255);
        for (int i = 0; i < 20; i++)
            send_pixel(dir_x[19 - i], dir_y[19 - i], i == 0);
        wait_idle();

        // clamped sizes, inverted thresholds
        set_frame(0, 0);
        cfg_write(REG_LOW_THRESH, 200);
        cfg_write(REG_HIGH_THRESH, 20);
        send_frame(1, -1);
        send_frame(0, -1);
        wait_idle();

        // width clamps to the line buffer depth: the line wraps after 1024 pixels
        set_frame(2047, 3);
        cfg_write(REG_L2_MODE, 0);
        send_frame(1, 1030);
        wait_idle();
        set_frame(5, 3);
        for (int i = 0; i < 6; i++)
            send_pixel(rand_grad(), rand_grad(), 1'b0);
        wait_idle();
        set_frame(6, 8191);
        send_frame(1, 40);
        wait_idle();

        // shrink the frame while mid-line, then continue without restart
        set_frame(10, 8);
        send_frame(1, 47);
        wait_idle();
        set_frame(5, 6);
        for (int i = 0; i < 20; i++)
            send_pixel(rand_grad(), rand_grad(), 1'b0);
        wait_idle();

        while (sent < 1250)
        begin
            wait_idle();
            set_frame(($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                  : $urandom_range(3, 12),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 8));
            cfg_write(REG_L2_MODE, $urandom_range(0, 1));
            cfg_write(REG_LOW_THRESH, $urandom_range(0, 255));
            cfg_write(REG_HIGH_THRESH, $urandom_range(0, 255));
            send_frame(1, -1);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 4) == 0)
                    send_frame(1, $urandom_range(1, frame_w * frame_h));
                else
                    send_frame($urandom_range(0, 1), -1);
                // resync after a broken frame
                send_frame(1, -1);
            end
        end

        wait_idle();
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/cnms_pkg.sv
src/cnms_regs.sv
src/cnms_mag.sv
src/cnms_window.sv
src/canny_non_max_suppression.sv
verif/cnms_checker.sv
verif/tb_top.sv
